// ===== rtl/core/gte_pkg.sv =====
// Shared types and codes for the graph trail edge tracer.
package gte_pkg;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_START  = 2'd2,
		CMD_MOVE   = 2'd3
	} gte_cmd_e;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NO_EDGE = 2'd1,
		ST_FULL    = 2'd2
	} gte_status_e;

	typedef enum logic [1:0] {
		S_IDLE   = 2'd0,
		S_SCAN   = 2'd1,
		S_FINISH = 2'd2,
		S_APPLY  = 2'd3
	} gte_state_e;

	typedef struct packed {
		logic [1:0] command;
		logic [3:0] node_first;
		logic [3:0] node_second;
	} gte_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] edge_index;
		logic [4:0] options_left;
		logic [4:0] trail_length;
		logic [3:0] here_node;
	} gte_result_t;

	typedef struct packed {
		logic clr;
		logic vld;
	} gte_scan_ctl_t;

endpackage

// ===== rtl/core/gte_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/gte_scan.sv =====
// Shared edge compare and count unit, fed one edge slot per cycle.
module gte_scan #(
	parameter int IDX_W = 4,
	parameter int CNT_W = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  gte_pkg::gte_scan_ctl_t ctl,
	input  logic [3:0]            end_one,
	input  logic [3:0]            end_two,
	input  logic                  used,
	input  logic [IDX_W-1:0]      idx,
	input  logic [3:0]            pos,
	input  logic [3:0]            dst,
	output logic                  found,
	output logic [IDX_W-1:0]      first,
	output logic [CNT_W-1:0]      cnt_pos,
	output logic [CNT_W-1:0]      cnt_dst
);

	logic             found_q;
	logic [IDX_W-1:0] first_q;
	logic [CNT_W-1:0] cnt_pos_q;
	logic [CNT_W-1:0] cnt_dst_q;
	logic             hit_pos;
	logic             hit_dst;
	logic             joins;

	always_comb begin
		hit_pos = !used && (end_one == pos || end_two == pos);
		hit_dst = !used && (end_one == dst || end_two == dst);
		joins   = !used && ((end_one == pos && end_two == dst) ||
			(end_one == dst && end_two == pos));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q   <= 1'b0;
			first_q   <= '0;
			cnt_pos_q <= '0;
			cnt_dst_q <= '0;
		end else if (ctl.clr) begin
			found_q   <= 1'b0;
			first_q   <= '0;
			cnt_pos_q <= '0;
			cnt_dst_q <= '0;
		end else if (ctl.vld) begin
			if (hit_pos) begin
				cnt_pos_q <= cnt_pos_q + 1'b1;
			end
			if (hit_dst) begin
				cnt_dst_q <= cnt_dst_q + 1'b1;
			end
			// lowest slot wins
			if (joins && !found_q) begin
				found_q <= 1'b1;
				first_q <= idx;
			end
		end
	end

	assign found   = found_q;
	assign first   = first_q;
	assign cnt_pos = cnt_pos_q;
	assign cnt_dst = cnt_dst_q;

endmodule

// ===== rtl/core/graph_trail_edge_tracer_core.sv =====
// Top level of the graph trail edge tracer: command sequencer, edge table and state.
//
// channel | signals             | handshake
// --------+---------------------+-------------------------------------------
// item in | start, busy, item   | taken at an edge with start high, busy low
// result  | done, result        | done high for one cycle, always taken
//
// Clear answers in the cycle after it is accepted. Append, start and move scan the edge
// table once through the shared compare unit, one slot per cycle from the table RAM,
// then pass through the finish and apply states, staying busy from accept until then.
// Reset empties the table and zeroes position, trail length and used marks.
// The result shows while busy is already low, so the next item may follow at once.
module graph_trail_edge_tracer_core #(
	parameter int EDGE_SLOTS = 16,
	parameter int NODE_COUNT = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  gte_pkg::gte_item_t   item,
	output logic                 busy,
	output logic                 done,
	output gte_pkg::gte_result_t result
);

	localparam int IDX_W = $clog2(EDGE_SLOTS);
	localparam int CNT_W = $clog2(EDGE_SLOTS + 1);
	localparam logic [8:0] NODE_N = 9'(NODE_COUNT);
	localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(EDGE_SLOTS);

	gte_pkg::gte_state_e   state_q;
	gte_pkg::gte_state_e   state_d;
	gte_pkg::gte_cmd_e     cmd_q;
	gte_pkg::gte_status_e  app_status_q;
	gte_pkg::gte_result_t  result_q;
	gte_pkg::gte_scan_ctl_t scan_ctl;
	logic                  done_q;
	logic [3:0]            dst_q;
	logic [3:0]            pos_q;
	logic [CNT_W-1:0]      stored_q;
	logic [CNT_W-1:0]      steps_q;
	logic [EDGE_SLOTS-1:0] used_q;
	logic [CNT_W-1:0]      idx_q;
	logic                  vld_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic [IDX_W-1:0]      app_idx_q;
	logic                  accept;
	logic                  rd_issue;
	logic                  wr_en;
	logic [8:0]            fold_a;
	logic [8:0]            fold_b;
	logic [3:0]            node_a;
	logic [3:0]            node_b;
	logic [7:0]            rd_ends;
	logic                  found;
	logic [IDX_W-1:0]      first;
	logic [CNT_W-1:0]      cnt_pos;
	logic [CNT_W-1:0]      cnt_dst;

	// node numbers folded modulo NODE_COUNT by repeated subtraction
	always_comb begin
		fold_a = {5'd0, item.node_first};
		fold_b = {5'd0, item.node_second};
		for (int k = 0; k < 8; k++) begin
			if (fold_a >= NODE_N) begin
				fold_a = fold_a - NODE_N;
			end
			if (fold_b >= NODE_N) begin
				fold_b = fold_b - NODE_N;
			end
		end
		node_a = fold_a[3:0];
		node_b = fold_b[3:0];
	end

	assign busy   = (state_q != gte_pkg::S_IDLE);
	assign accept = start && !busy;
	assign wr_en  = accept && (item.command == gte_pkg::CMD_APPEND) && (stored_q < SLOTS_C);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gte_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		rd_issue     = 1'b0;
		scan_ctl.clr = accept && (item.command != gte_pkg::CMD_CLEAR);
		scan_ctl.vld = vld_s1;
		case (state_q)
			gte_pkg::S_IDLE: begin
				if (accept && item.command != gte_pkg::CMD_CLEAR) begin
					state_d = gte_pkg::S_SCAN;
				end
			end
			gte_pkg::S_SCAN: begin
				if (idx_q < stored_q) begin
					rd_issue = 1'b1;
				end else begin
					state_d = gte_pkg::S_FINISH;
				end
			end
			gte_pkg::S_FINISH: begin
				state_d = gte_pkg::S_APPLY;
			end
			gte_pkg::S_APPLY: begin
				state_d = gte_pkg::S_IDLE;
			end
			default: begin
				state_d = gte_pkg::S_IDLE;
			end
		endcase
	end

	gte_ram #(
		.WIDTH(8),
		.DEPTH(EDGE_SLOTS)
	) u_ends (
		.clk  (clk),
		.we   (wr_en),
		.waddr(stored_q[IDX_W-1:0]),
		.wdata({node_a, node_b}),
		.raddr(idx_q[IDX_W-1:0]),
		.rdata(rd_ends)
	);

	gte_scan #(
		.IDX_W(IDX_W),
		.CNT_W(CNT_W)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (scan_ctl),
		.end_one(rd_ends[7:4]),
		.end_two(rd_ends[3:0]),
		.used   (used_q[idx_s1]),
		.idx    (idx_s1),
		.pos    (pos_q),
		.dst    (dst_q),
		.found  (found),
		.first  (first),
		.cnt_pos(cnt_pos),
		.cnt_dst(cnt_dst)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q   <= 1'b0;
			vld_s1   <= 1'b0;
			idx_q    <= '0;
			stored_q <= '0;
			steps_q  <= '0;
			pos_q    <= '0;
			used_q   <= '0;
		end else begin
			done_q <= (accept && item.command == gte_pkg::CMD_CLEAR) ||
				(state_q == gte_pkg::S_APPLY);
			vld_s1 <= rd_issue;
			if (rd_issue) begin
				idx_q <= idx_q + 1'b1;
			end
			if (accept) begin
				idx_q <= '0;
				case (item.command)
					gte_pkg::CMD_CLEAR: begin
						stored_q <= '0;
						used_q   <= '0;
						steps_q  <= '0;
					end
					gte_pkg::CMD_APPEND: begin
						if (stored_q < SLOTS_C) begin
							used_q[stored_q[IDX_W-1:0]] <= 1'b0;
							stored_q <= stored_q + 1'b1;
						end
					end
					gte_pkg::CMD_START: begin
						pos_q   <= node_a;
						used_q  <= '0;
						steps_q <= '0;
					end
					default: begin
					end
				endcase
			end
			if (state_q == gte_pkg::S_APPLY) begin
				if (cmd_q == gte_pkg::CMD_MOVE && found) begin
					used_q[first] <= 1'b1;
					steps_q       <= steps_q + 1'b1;
					pos_q         <= dst_q;
				end
			end
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		idx_s1 <= idx_q[IDX_W-1:0];
		if (accept) begin
			cmd_q <= gte_pkg::gte_cmd_e'(item.command);
			dst_q <= node_a;
			if (stored_q < SLOTS_C) begin
				app_status_q <= gte_pkg::ST_OK;
				app_idx_q    <= stored_q[IDX_W-1:0];
			end else begin
				app_status_q <= gte_pkg::ST_FULL;
				app_idx_q    <= '0;
			end
			if (item.command == gte_pkg::CMD_CLEAR) begin
				result_q.status       <= gte_pkg::ST_OK;
				result_q.edge_index   <= '0;
				result_q.options_left <= '0;
				result_q.trail_length <= '0;
				result_q.here_node    <= pos_q;
			end
		end
		if (state_q == gte_pkg::S_APPLY) begin
			case (cmd_q)
				gte_pkg::CMD_MOVE: begin
					if (found) begin
						result_q.status       <= gte_pkg::ST_OK;
						result_q.edge_index   <= 4'(first);
						result_q.options_left <= 5'(cnt_dst - 1'b1);
						result_q.trail_length <= 5'(steps_q + 1'b1);
						result_q.here_node    <= dst_q;
					end else begin
						result_q.status       <= gte_pkg::ST_NO_EDGE;
						result_q.edge_index   <= '0;
						result_q.options_left <= 5'(cnt_pos);
						result_q.trail_length <= 5'(steps_q);
						result_q.here_node    <= pos_q;
					end
				end
				gte_pkg::CMD_APPEND: begin
					result_q.status       <= app_status_q;
					result_q.edge_index   <= 4'(app_idx_q);
					result_q.options_left <= 5'(cnt_pos);
					result_q.trail_length <= 5'(steps_q);
					result_q.here_node    <= pos_q;
				end
				default: begin
					result_q.status       <= gte_pkg::ST_OK;
					result_q.edge_index   <= '0;
					result_q.options_left <= 5'(cnt_pos);
					result_q.trail_length <= 5'(steps_q);
					result_q.here_node    <= pos_q;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_scan_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.command != gte_pkg::CMD_CLEAR) |=> busy)
		else $error("scan command did not start a scan");

	a_clear_fast: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.command == gte_pkg::CMD_CLEAR) |=> (done && !busy))
		else $error("clear did not answer in one cycle");

	a_trail_bound: assert property (@(posedge clk) disable iff (!arst_n)
		steps_q <= stored_q)
		else $error("trail longer than edge table");

endmodule
